@@ rtl/core/dual_stack_shared_memory_macros.svh @@
// Assertion macros for the file that checks the stack block.
`ifndef DUAL_STACK_SHARED_MEMORY_MACROS_SVH
`define DUAL_STACK_SHARED_MEMORY_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DSSM_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("stack block check failed");

// The consequent must hold in the cycle after the antecedent.
`define DSSM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("stack block check failed");

`endif

@@ rtl/core/dssm_pkg.sv @@
`timescale 1ns / 1ps

package dssm_pkg;

    // Widths of the fields that cross the block boundary.
    localparam int CAP_W   = 9;
    localparam int CNT_O_W = 9;
    localparam int DATA_O_W = 32;

    // Operation codes.
    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_PEEK = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OVFL  = 2'd1;
    localparam logic [1:0] ST_UNDFL = 2'd2;

    // One request item.
    typedef struct packed {
        logic [1:0]                 op;
        logic                       stack_sel;
        logic signed [DATA_O_W-1:0] push_data;
    } in_t;

    // One result item.
    typedef struct packed {
        logic signed [DATA_O_W-1:0] read_data;
        logic [1:0]                 status;
        logic [CNT_O_W-1:0]         count_low;
        logic [CNT_O_W-1:0]         count_high;
        logic                       empty_low;
        logic                       empty_high;
        logic                       full_res;
    } out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic load_rdata;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_read;
    } dp_status_t;

endpackage

@@ rtl/core/dssm_ram.sv @@
`timescale 1ns / 1ps

module dssm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/dssm_datapath.sv @@
`timescale 1ns / 1ps

module dssm_datapath #(
    parameter int DEPTH      = 256,
    parameter int DATA_WIDTH = 32
) (
    input  logic                      clk,
    input  logic                      rstn,
    input  logic                      cfg_wr_en,
    input  logic [dssm_pkg::CAP_W-1:0] cfg_wr_data,
    input  dssm_pkg::in_t             in_item,
    input  dssm_pkg::ctrl_cmd_t       cmd,
    output dssm_pkg::dp_status_t      status,
    output dssm_pkg::out_t            out_item
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int AW    = $clog2(DEPTH);

    logic [CNT_W-1:0]      cap_reg, cap_next;
    logic [CNT_W-1:0]      low_cnt_reg, low_cnt_next;
    logic [CNT_W-1:0]      high_cnt_reg, high_cnt_next;
    logic [CNT_W-1:0]      cfg_cap;
    logic [CNT_W:0]        sum_now, sum_next;
    logic                  full_now;
    logic                  sel_empty;
    logic                  push_ok;
    logic                  read_ok;
    logic [1:0]            st;
    logic [CNT_W-1:0]      wr_ptr, rd_ptr;
    logic [DATA_WIDTH-1:0] ram_rdata;
    dssm_pkg::out_t        out_reg, out_next;

    // Saturate a capacity write into the range one to DEPTH.
    always_comb begin
        if (cfg_wr_data == '0) begin
            cfg_cap = CNT_W'(1);
        end else if (32'(cfg_wr_data) > 32'(DEPTH)) begin
            cfg_cap = CNT_W'(DEPTH);
        end else begin
            cfg_cap = CNT_W'(cfg_wr_data);
        end
    end

    // Decide the outcome of the item at the input.
    assign sum_now   = {1'b0, low_cnt_reg} + {1'b0, high_cnt_reg};
    assign full_now  = sum_now >= {1'b0, cap_reg};
    assign sel_empty = in_item.stack_sel ? (high_cnt_reg == '0) : (low_cnt_reg == '0);

    always_comb begin
        push_ok       = 1'b0;
        read_ok       = 1'b0;
        st            = dssm_pkg::ST_OK;
        low_cnt_next  = low_cnt_reg;
        high_cnt_next = high_cnt_reg;
        unique case (in_item.op)
            dssm_pkg::OP_PUSH: begin
                if (full_now) begin
                    st = dssm_pkg::ST_OVFL;
                end else begin
                    push_ok = 1'b1;
                    if (in_item.stack_sel) begin
                        high_cnt_next = high_cnt_reg + CNT_W'(1);
                    end else begin
                        low_cnt_next = low_cnt_reg + CNT_W'(1);
                    end
                end
            end
            dssm_pkg::OP_POP, dssm_pkg::OP_PEEK: begin
                if (sel_empty) begin
                    st = dssm_pkg::ST_UNDFL;
                end else begin
                    read_ok = 1'b1;
                    if (in_item.op == dssm_pkg::OP_POP) begin
                        if (in_item.stack_sel) begin
                            high_cnt_next = high_cnt_reg - CNT_W'(1);
                        end else begin
                            low_cnt_next = low_cnt_reg - CNT_W'(1);
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign status.need_read = read_ok;

    // The low stack grows up from entry zero, the high stack down from capacity minus one.
    assign wr_ptr = in_item.stack_sel ? (cap_reg - CNT_W'(1) - high_cnt_reg) : low_cnt_reg;
    assign rd_ptr = in_item.stack_sel ? (cap_reg - high_cnt_reg) : (low_cnt_reg - CNT_W'(1));

    dssm_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.accept && push_ok),
        .waddr (wr_ptr[AW-1:0]),
        .wdata (DATA_WIDTH'($unsigned(in_item.push_data))),
        .re    (cmd.accept && read_ok),
        .raddr (rd_ptr[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Stack pointers and capacity; a capacity write empties both stacks.
    always_comb begin
        cap_next = cap_reg;
        if (cfg_wr_en) begin
            cap_next = cfg_cap;
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            cap_reg      <= CNT_W'(DEPTH);
            low_cnt_reg  <= '0;
            high_cnt_reg <= '0;
        end else begin
            cap_reg <= cap_next;
            if (cfg_wr_en) begin
                low_cnt_reg  <= '0;
                high_cnt_reg <= '0;
            end else if (cmd.accept) begin
                low_cnt_reg  <= low_cnt_next;
                high_cnt_reg <= high_cnt_next;
            end
        end
    end

    // Result register: sizes and flags at accept, read data in the cycle after.
    assign sum_next = {1'b0, low_cnt_next} + {1'b0, high_cnt_next};

    always_comb begin
        out_next = out_reg;
        if (cmd.accept) begin
            out_next.read_data  = '0;
            out_next.status     = st;
            out_next.count_low  = dssm_pkg::CNT_O_W'(low_cnt_next);
            out_next.count_high = dssm_pkg::CNT_O_W'(high_cnt_next);
            out_next.empty_low  = (low_cnt_next == '0);
            out_next.empty_high = (high_cnt_next == '0);
            out_next.full_res   = sum_next >= {1'b0, cap_reg};
        end else if (cmd.load_rdata) begin
            out_next.read_data = $signed(dssm_pkg::DATA_O_W'(ram_rdata));
        end
    end

    always_ff @(posedge clk) begin
        out_reg <= out_next;
    end

    assign out_item = out_reg;

endmodule

@@ rtl/core/dssm_ctrl.sv @@
`timescale 1ns / 1ps

module dssm_ctrl (
    input  logic                 clk,
    input  logic                 rstn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  dssm_pkg::dp_status_t status,
    output dssm_pkg::ctrl_cmd_t  cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic state_reg, state_next;
    logic m_valid_reg, m_valid_next;
    logic accept;

    // An item is taken when idle and the result register is free or draining.
    assign s_ready = (state_reg == S_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    assign cmd.accept     = accept;
    assign cmd.load_rdata = (state_reg == S_READ);

    // A successful pop or peek waits in S_READ for the memory read.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept && status.need_read) begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result valid flag.
    always_comb begin
        priority if (state_reg == S_READ) begin
            m_valid_next = 1'b1;
        end else if (accept) begin
            m_valid_next = !status.need_read;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

@@ rtl/core/dual_stack_shared_memory.sv @@
`timescale 1ns / 1ps

// Two LIFO stacks in one memory of up to DEPTH entries: the low stack grows up
// from entry zero, the high stack down from entry capacity minus one. A
// successful pop or peek passes through a read state, because the memory read
// is registered. A new item is taken only while no read is pending and the
// result register is empty or its result is taken in the same cycle, so a
// stalled result side holds off the input.
// Writing the capacity register empties both stacks at once; there is no
// clearing pass, and stored entries are undefined until pushed.

`include "dual_stack_shared_memory_macros.svh"

module dual_stack_shared_memory #(
    parameter int DEPTH      = 256,
    parameter int DATA_WIDTH = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [dssm_pkg::CAP_W-1:0] cfg_wr_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  dssm_pkg::in_t              s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output dssm_pkg::out_t             m_data
);

    dssm_pkg::ctrl_cmd_t  cmd;
    dssm_pkg::dp_status_t dp_status;

    // Sequencing of items and the result handshake.
    dssm_ctrl u_ctrl (
        .clk     (aclk),
        .rstn    (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (dp_status),
        .cmd     (cmd)
    );

    // Stack pointers, shared memory and result register.
    dssm_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk         (aclk),
        .rstn        (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_item     (s_data),
        .cmd         (cmd),
        .status      (dp_status),
        .out_item    (m_data)
    );

    // A read always completes into the result register in the following cycle.
    `DSSM_ASSERT_NEXT(a_read_completes, aclk, aresetn, cmd.load_rdata, m_valid)
    // No item is taken while the memory read is still outstanding.
    `DSSM_ASSERT_SAME(a_no_accept_in_read, aclk, aresetn, cmd.load_rdata, !s_ready)
    // A failed item never returns data.
    `DSSM_ASSERT_SAME(a_err_no_data, aclk, aresetn,
        m_valid && (m_data.status != dssm_pkg::ST_OK), m_data.read_data == '0)
    // The low empty flag agrees with the reported low size.
    `DSSM_ASSERT_SAME(a_empty_flag, aclk, aresetn, m_valid,
        m_data.empty_low == (m_data.count_low == '0))

endmodule
